[rtl/lccd_pkg.sv]
// Package for the linear CCD capture sequencer: item structs, sequence phase
// codes, register indexes and reset values of the configuration registers.
// No dependencies.
`default_nettype none

package lccd_pkg;

   // Converter width and the mask applied to the sampled value
   localparam int unsigned ADC_BITS = 12;
   localparam logic [11:0] ADC_MASK = 12'((64'd1 << ADC_BITS) - 64'd1);

   // Fixed tail of the transfer: master cycles after the shift pulse
   localparam logic [15:0] XTAIL_CYCLES = 16'd4;
   // Tail cycle at which the integration gate rises again
   localparam logic [15:0] XTAIL_ICG_RISE = 16'd3;
   // Readout tick that samples the converter value
   localparam logic [1:0] LAST_TICK = 2'd3;
   // Shift pulse repeats every third readout period
   localparam logic [1:0] THIRD_WRAP = 2'd2;

   // Configuration register indexes
   localparam logic [2:0] CSR_INTEGRATION_CYCLES = 3'd0;
   localparam logic [2:0] CSR_SAMPLE_PHASE       = 3'd1;
   localparam logic [2:0] CSR_CLEAR_PULSES       = 3'd2;
   localparam logic [2:0] CSR_SHIFT_HIGH_CYCLES  = 3'd3;
   localparam logic [2:0] CSR_SHIFT_LOW_CYCLES   = 3'd4;
   localparam logic [2:0] CSR_READOUT_PERIODS    = 3'd5;
   localparam logic [2:0] CSR_ACTIVE_START       = 3'd6;
   localparam logic [2:0] CSR_PIXEL_COUNT        = 3'd7;

   // Register reset values
   localparam logic [15:0] RST_INTEGRATION_CYCLES = 16'd50;
   localparam logic [1:0]  RST_SAMPLE_PHASE       = 2'd0;
   localparam logic [15:0] RST_CLEAR_PULSES       = 16'd4166;
   localparam logic [7:0]  RST_SHIFT_HIGH_CYCLES  = 8'd2;
   localparam logic [7:0]  RST_SHIFT_LOW_CYCLES   = 8'd4;
   localparam logic [11:0] RST_READOUT_PERIODS    = 12'd1546;
   localparam logic [11:0] RST_ACTIVE_START       = 12'd32;
   localparam logic [11:0] RST_PIXEL_COUNT        = 12'd1500;

   // Sequence phases, one-hot
   typedef enum logic [6:0] {
      PH_IDLE  = 7'b0000001,
      PH_CLEAR = 7'b0000010,
      PH_INTEG = 7'b0000100,
      PH_HOLD  = 7'b0001000,
      PH_XHIGH = 7'b0010000,
      PH_XTAIL = 7'b0100000,
      PH_READ  = 7'b1000000
   } lccd_phase_type;

   // Input item: tick or start request, plus the converter value
   typedef struct packed {
      logic        req_type;
      logic [11:0] adc_value;
   } lccd_req_type;

   // Result item: pin levels, strobe, status and pixel
   typedef struct packed {
      logic        phim;
      logic        icg;
      logic        sh;
      logic        adc_start;
      logic        busy_res;
      logic        pixel_valid;
      logic [11:0] pixel_index;
      logic [11:0] pixel_value;
      logic        last_pixel;
   } lccd_rsp_type;

endpackage

`default_nettype wire

[rtl/linear_ccd_capture_sequencer_top.sv]
// Linear CCD capture sequencer: timing generator for the sensor pins, ADC
// strobe and pixel extraction, one master half period per tick item.
// Depends on lccd_pkg.
//
//   channel | direction | ports                           | moves
//   req     | in        | req_valid req_ready req_data    | tick or start item
//   rsp     | out       | rsp_valid rsp_ready rsp_data    | one result per item
//   csr     | in        | csr_we csr_addr csr_wdata       | register write
//
// Every accepted item is processed in the cycle it is accepted; its result sits
// in the output register from the next cycle on. One item per cycle sustained while rsp_ready takes each result.
// req_ready is low only while the output register holds a result that
// rsp_ready does not take. Synchronous active-high reset returns the sequencer
// to idle with PHIM and ICG high, SH low, and the registers at defaults.
`default_nettype none

module linear_ccd_capture_sequencer_top
   import lccd_pkg::*;
#(
   parameter int unsigned ADC_WIDTH = ADC_BITS
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire lccd_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output lccd_rsp_type      rsp_data,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_addr,
   input  wire logic [15:0]  csr_wdata
);

   // Converter bits kept from the sampled value
   localparam logic [11:0] ADC_KEEP = 12'((64'd1 << ADC_WIDTH) - 64'd1);

   // Configuration registers
   logic [15:0] integ_cycles_ff;
   logic [1:0]  sample_phase_ff;
   logic [15:0] clear_pulses_ff;
   logic [7:0]  shift_high_ff;
   logic [7:0]  shift_low_ff;
   logic [11:0] readout_periods_ff;
   logic [11:0] active_start_ff;
   logic [11:0] pixel_count_ff;

   // Sequencer state
   lccd_phase_type phase_ff, phase_in;
   logic [15:0] pulse_ff, pulse_in;
   logic [15:0] cycle_ff, cycle_in;
   logic [1:0]  half_ff, half_in;
   logic [11:0] period_ff, period_in;
   logic [1:0]  third_ff, third_in;
   logic        phim_ff, phim_in;
   logic        icg_ff, icg_in;
   logic        sh_ff, sh_in;

   // Output register
   logic         rsp_valid_ff;
   lccd_rsp_type rsp_data_ff, rsp_data_in;

   logic accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_cycles_ff    <= RST_INTEGRATION_CYCLES;
         sample_phase_ff    <= RST_SAMPLE_PHASE;
         clear_pulses_ff    <= RST_CLEAR_PULSES;
         shift_high_ff      <= RST_SHIFT_HIGH_CYCLES;
         shift_low_ff       <= RST_SHIFT_LOW_CYCLES;
         readout_periods_ff <= RST_READOUT_PERIODS;
         active_start_ff    <= RST_ACTIVE_START;
         pixel_count_ff     <= RST_PIXEL_COUNT;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_INTEGRATION_CYCLES: integ_cycles_ff    <= csr_wdata;
            CSR_SAMPLE_PHASE:       sample_phase_ff    <= csr_wdata[1:0];
            CSR_CLEAR_PULSES:       clear_pulses_ff    <= csr_wdata;
            CSR_SHIFT_HIGH_CYCLES:  shift_high_ff      <= csr_wdata[7:0];
            CSR_SHIFT_LOW_CYCLES:   shift_low_ff       <= csr_wdata[7:0];
            CSR_READOUT_PERIODS:    readout_periods_ff <= csr_wdata[11:0];
            CSR_ACTIVE_START:       active_start_ff    <= csr_wdata[11:0];
            CSR_PIXEL_COUNT:        pixel_count_ff     <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // Next state and result for one item
   always_comb begin
      lccd_phase_type ph;
      logic [15:0] pc;
      logic [15:0] cc;
      logic [1:0]  ht;
      logic [11:0] per;
      logic [1:0]  thr;
      logic [8:0]  pulse_len;
      logic [11:0] rel;

      ph  = phase_ff;
      pc  = pulse_ff;
      cc  = cycle_ff;
      ht  = half_ff;
      per = period_ff;
      thr = third_ff;
      rel = period_ff - active_start_ff;
      pulse_len = {1'b0, shift_high_ff} + {1'b0, shift_low_ff};

      phim_in = phim_ff;
      icg_in  = icg_ff;
      sh_in   = sh_ff;
      rsp_data_in = '0;

      if (req_data.req_type) begin
         // Start request: launch only from idle, pins hold
         if (phase_ff == PH_IDLE) begin
            ph  = PH_CLEAR;
            pc  = '0;
            cc  = '0;
            ht  = '0;
            per = '0;
            thr = '0;
         end
         rsp_data_in.busy_res = 1'b1;
      end else begin
         // Skip segments that are finished or empty
         if (ph == PH_CLEAR) begin
            if (pulse_len == 9'd0 || pc >= clear_pulses_ff) begin
               ph = PH_INTEG;
               cc = '0;
               ht = '0;
            end else if (cc >= {7'd0, pulse_len}) begin
               pc = pc + 16'd1;
               cc = '0;
               if (pc >= clear_pulses_ff) begin
                  ph = PH_INTEG;
                  ht = '0;
               end
            end
         end
         if (ph == PH_INTEG && cc >= integ_cycles_ff) begin
            ph = PH_HOLD;
            cc = '0;
            ht = '0;
         end
         if (ph == PH_XHIGH && cc >= {8'd0, shift_high_ff}) begin
            ph = PH_XTAIL;
            cc = '0;
            ht = '0;
         end
         if (ph == PH_XTAIL && cc >= XTAIL_CYCLES) begin
            ph  = PH_READ;
            per = '0;
            thr = '0;
            ht  = '0;
         end
         if (ph == PH_READ && per >= readout_periods_ff) begin
            ph = PH_IDLE;
            ht = '0;
         end
         rel = per - active_start_ff;

         // Drive pins for this tick and advance counters
         case (ph)
            PH_CLEAR, PH_INTEG, PH_XHIGH, PH_XTAIL: begin
               rsp_data_in.busy_res = 1'b1;
               phim_in = ht[0];
               if (ph == PH_CLEAR) begin
                  icg_in = 1'b1;
                  sh_in  = (cc < {8'd0, shift_high_ff});
               end else if (ph == PH_INTEG) begin
                  icg_in = 1'b1;
                  sh_in  = 1'b0;
               end else if (ph == PH_XHIGH) begin
                  icg_in = 1'b0;
                  sh_in  = 1'b1;
               end else begin
                  icg_in = (cc >= XTAIL_ICG_RISE);
                  sh_in  = 1'b0;
               end
               if (ht != 2'd0) begin
                  ht = '0;
                  cc = cc + 16'd1;
               end else begin
                  ht = 2'd1;
               end
            end
            PH_HOLD: begin
               rsp_data_in.busy_res = 1'b1;
               phim_in = 1'b1;
               icg_in  = 1'b0;
               sh_in   = 1'b0;
               ph = PH_XHIGH;
               cc = '0;
               ht = '0;
            end
            PH_READ: begin
               rsp_data_in.busy_res  = 1'b1;
               phim_in = ht[0];
               icg_in  = 1'b1;
               sh_in   = (thr == 2'd0);
               rsp_data_in.adc_start = (ht == sample_phase_ff);
               if (ht == LAST_TICK) begin
                  // Emit the pixel when the period lies in the active window
                  if (per >= active_start_ff && rel < pixel_count_ff) begin
                     rsp_data_in.pixel_valid = 1'b1;
                     rsp_data_in.pixel_index = rel;
                     rsp_data_in.pixel_value = req_data.adc_value & ADC_KEEP;
                     rsp_data_in.last_pixel  =
                        (({1'b0, rel} + 13'd1) == {1'b0, pixel_count_ff});
                  end
                  per = per + 12'd1;
                  thr = (thr >= THIRD_WRAP) ? 2'd0 : thr + 2'd1;
                  ht  = '0;
               end else begin
                  ht = ht + 2'd1;
               end
            end
            default: begin
               ph = PH_IDLE;
               phim_in = 1'b1;
               icg_in  = 1'b1;
               sh_in   = 1'b0;
            end
         endcase
      end

      phase_in  = ph;
      pulse_in  = pc;
      cycle_in  = cc;
      half_in   = ht;
      period_in = per;
      third_in  = thr;
      rsp_data_in.phim = phim_in;
      rsp_data_in.icg  = icg_in;
      rsp_data_in.sh   = sh_in;
   end

   // Advance state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pulse_ff  <= '0;
         cycle_ff  <= '0;
         half_ff   <= '0;
         period_ff <= '0;
         third_ff  <= '0;
         phim_ff   <= 1'b1;
         icg_ff    <= 1'b1;
         sh_ff     <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         pulse_ff  <= pulse_in;
         cycle_ff  <= cycle_in;
         half_ff   <= half_in;
         period_ff <= period_in;
         third_ff  <= third_in;
         phim_ff   <= phim_in;
         icg_ff    <= icg_in;
         sh_ff     <= sh_in;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Start from idle enters the clearing phase
   a_start_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.req_type && phase_ff == PH_IDLE) |=> phase_ff == PH_CLEAR)
      else $error("start from idle did not enter clearing");

   // Pixels only come out of a running capture
   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.pixel_valid) |-> rsp_data_ff.busy_res)
      else $error("pixel outside a capture");

   // Last marker only on a pixel
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.last_pixel) |-> rsp_data_ff.pixel_valid)
      else $error("last marker without pixel");

   // ADC strobe only during readout, where ICG is high
   a_strobe_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.adc_start) |-> (rsp_data_ff.busy_res && rsp_data_ff.icg))
      else $error("ADC strobe outside readout");

   // Half tick runs past one only in readout
   a_half_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_READ) |-> !half_ff[1])
      else $error("half tick out of range");

endmodule

`default_nettype wire

[sim/linear_ccd_capture_sequencer_top_test.sv]
// Testbench for linear_ccd_capture_sequencer_top: a clocked driver and monitor
// compare every result against an in-bench sequencer forecast, field by field.
// Depends on lccd_pkg and the sequencer RTL.
`default_nettype none

module linear_ccd_capture_sequencer_top_test
   import lccd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_OFF_CYCLES = 200;
   localparam int unsigned SETTING_ITEMS = 240;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   lccd_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   lccd_rsp_type rsp_data;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_addr = '0;
   logic [15:0]  csr_wdata = '0;

   linear_ccd_capture_sequencer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // Register shadow, kept in step with every write
   logic [15:0] cfg_integ   = RST_INTEGRATION_CYCLES;
   logic [1:0]  cfg_phase   = RST_SAMPLE_PHASE;
   logic [15:0] cfg_clear   = RST_CLEAR_PULSES;
   logic [7:0]  cfg_shi     = RST_SHIFT_HIGH_CYCLES;
   logic [7:0]  cfg_slo     = RST_SHIFT_LOW_CYCLES;
   logic [11:0] cfg_periods = RST_READOUT_PERIODS;
   logic [11:0] cfg_astart  = RST_ACTIVE_START;
   logic [11:0] cfg_npix    = RST_PIXEL_COUNT;

   // Forecast state of the sequencer
   lccd_phase_type seq_phase = PH_IDLE;
   logic [15:0]    seq_pulses = '0;
   logic [15:0]    seq_cycles = '0;
   logic [1:0]     seq_half = '0;
   logic [11:0]    seq_period = '0;
   logic [1:0]     seq_third = '0;
   logic           lvl_phim = 1'b1;
   logic           lvl_icg = 1'b1;
   logic           lvl_sh = 1'b0;

   lccd_req_type tick_queue[$];
   lccd_rsp_type awaited_outputs[$];

   int unsigned send_idle_pct = 18;
   int unsigned recv_idle_pct = 78;
   int unsigned hold_requests = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;
   int unsigned items_queued = 0;
   int unsigned items_taken = 0;
   int unsigned outputs_checked = 0;
   int unsigned pixels_seen = 0;
   int unsigned line_ends_seen = 0;
   int unsigned captures_run = 0;
   int unsigned n_fail = 0;
   int unsigned cycles_run = 0;

   // Half period of the master clock: PHIM follows the half, cycle advances on the second
   function automatic void master_half_tick();
      lvl_phim = seq_half[0];
      if (seq_half != 2'd0) begin
         seq_half = 2'd0;
         seq_cycles = seq_cycles + 16'd1;
      end else begin
         seq_half = 2'd1;
      end
   endfunction

   // Drop every segment whose counter already reached its limit
   function automatic void settle_segments();
      int unsigned pulse_len;
      bit          moved;
      pulse_len = int'(cfg_shi) + int'(cfg_slo);
      moved = 1'b1;
      while (moved) begin
         moved = 1'b0;
         case (seq_phase)
            PH_CLEAR: begin
               if (pulse_len == 0 || seq_pulses >= cfg_clear) begin
                  seq_phase = PH_INTEG;
                  seq_cycles = '0;
                  seq_half = '0;
                  moved = 1'b1;
               end else if (seq_cycles >= pulse_len) begin
                  seq_pulses = seq_pulses + 16'd1;
                  seq_cycles = '0;
                  moved = 1'b1;
               end
            end
            PH_INTEG: begin
               if (seq_cycles >= cfg_integ) begin
                  seq_phase = PH_HOLD;
                  seq_cycles = '0;
                  seq_half = '0;
                  moved = 1'b1;
               end
            end
            PH_XHIGH: begin
               if (seq_cycles >= cfg_shi) begin
                  seq_phase = PH_XTAIL;
                  seq_cycles = '0;
                  seq_half = '0;
                  moved = 1'b1;
               end
            end
            PH_XTAIL: begin
               if (seq_cycles >= XTAIL_CYCLES) begin
                  seq_phase = PH_READ;
                  seq_period = '0;
                  seq_third = '0;
                  seq_half = '0;
                  moved = 1'b1;
               end
            end
            PH_READ: begin
               if (seq_period >= cfg_periods) begin
                  seq_phase = PH_IDLE;
                  seq_half = '0;
               end
            end
            default: ;
         endcase
      end
   endfunction

   // Advance the sequencer forecast by one item and return the pins it drives
   function automatic lccd_rsp_type sequencer_advance(lccd_req_type item);
      lccd_rsp_type r;
      int unsigned  rel;
      r = '0;
      if (item.req_type) begin
         if (seq_phase == PH_IDLE) begin
            seq_phase = PH_CLEAR;
            seq_pulses = '0;
            seq_cycles = '0;
            seq_half = '0;
            seq_period = '0;
            seq_third = '0;
         end
         r.busy_res = 1'b1;
      end else begin
         settle_segments();
         r.busy_res = (seq_phase != PH_IDLE);
         case (seq_phase)
            PH_CLEAR: begin
               lvl_icg = 1'b1;
               lvl_sh = (seq_cycles < cfg_shi);
               master_half_tick();
            end
            PH_INTEG: begin
               lvl_icg = 1'b1;
               lvl_sh = 1'b0;
               master_half_tick();
            end
            PH_HOLD: begin
               lvl_phim = 1'b1;
               lvl_icg = 1'b0;
               lvl_sh = 1'b0;
               seq_phase = PH_XHIGH;
               seq_cycles = '0;
               seq_half = '0;
            end
            PH_XHIGH: begin
               lvl_icg = 1'b0;
               lvl_sh = 1'b1;
               master_half_tick();
            end
            PH_XTAIL: begin
               lvl_icg = (seq_cycles >= XTAIL_ICG_RISE);
               lvl_sh = 1'b0;
               master_half_tick();
            end
            PH_READ: begin
               lvl_phim = seq_half[0];
               lvl_icg = 1'b1;
               lvl_sh = (seq_third == 2'd0);
               r.adc_start = (seq_half == cfg_phase);
               if (seq_half == LAST_TICK) begin
                  // sample on the fourth tick when the period lies in the window
                  if (seq_period >= cfg_astart) begin
                     rel = seq_period - cfg_astart;
                     if (rel < cfg_npix) begin
                        r.pixel_valid = 1'b1;
                        r.pixel_index = rel[11:0];
                        r.pixel_value = item.adc_value & ADC_MASK;
                        r.last_pixel = (rel + 1 == cfg_npix);
                     end
                  end
                  seq_period = seq_period + 12'd1;
                  seq_third = (seq_third >= THIRD_WRAP) ? 2'd0 : seq_third + 2'd1;
                  seq_half = '0;
               end else begin
                  seq_half = seq_half + 2'd1;
               end
            end
            default: begin
               seq_phase = PH_IDLE;
               lvl_phim = 1'b1;
               lvl_icg = 1'b1;
               lvl_sh = 1'b0;
               r.busy_res = 1'b0;
            end
         endcase
      end
      r.phim = lvl_phim;
      r.icg = lvl_icg;
      r.sh = lvl_sh;
      return r;
   endfunction

   function automatic void cmp_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         n_fail++;
      end
   endfunction

   function automatic void check_output(lccd_rsp_type want, lccd_rsp_type got);
      cmp_field("phim", 32'(want.phim), 32'(got.phim));
      cmp_field("icg", 32'(want.icg), 32'(got.icg));
      cmp_field("sh", 32'(want.sh), 32'(got.sh));
      cmp_field("adc_start", 32'(want.adc_start), 32'(got.adc_start));
      cmp_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
      cmp_field("pixel_valid", 32'(want.pixel_valid), 32'(got.pixel_valid));
      cmp_field("pixel_index", 32'(want.pixel_index), 32'(got.pixel_index));
      cmp_field("pixel_value", 32'(want.pixel_value), 32'(got.pixel_value));
      cmp_field("last_pixel", 32'(want.last_pixel), 32'(got.last_pixel));
   endfunction

   // Clock and reset
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Driver: offer the next pending item, hold it until it is taken
   always @(posedge clock) begin : item_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_outputs.push_back(sequencer_advance(req_data));
            items_taken++;
         end
         if (!req_valid || req_ready) begin
            if (tick_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= tick_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result against the oldest forecast, stall at random
   always @(posedge clock) begin : output_monitor
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_outputs.size() == 0) begin
               $error("result with no item outstanding: %h", rsp_data);
               n_fail++;
            end else begin
               check_output(awaited_outputs.pop_front(), rsp_data);
               outputs_checked++;
               if (rsp_data.pixel_valid) pixels_seen++;
               if (rsp_data.last_pixel) line_ends_seen++;
            end
         end
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog
   initial begin
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("linear_ccd_capture_sequencer_top_test: FAIL");
      $finish;
   end

   task automatic queue_item(logic is_start, logic [11:0] adc);
      lccd_req_type item;
      item.req_type = is_start;
      item.adc_value = adc;
      tick_queue.push_back(item);
      items_queued++;
   endtask

   // Write one register and mirror it in the shadow
   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_INTEGRATION_CYCLES: cfg_integ = val;
         CSR_SAMPLE_PHASE:       cfg_phase = val[1:0];
         CSR_CLEAR_PULSES:       cfg_clear = val;
         CSR_SHIFT_HIGH_CYCLES:  cfg_shi = val[7:0];
         CSR_SHIFT_LOW_CYCLES:   cfg_slo = val[7:0];
         CSR_READOUT_PERIODS:    cfg_periods = val[11:0];
         CSR_ACTIVE_START:       cfg_astart = val[11:0];
         CSR_PIXEL_COUNT:        cfg_npix = val[11:0];
         default: ;
      endcase
   endtask

   task automatic load_config(logic [15:0] integ, logic [1:0] phase, logic [15:0] clear,
                              logic [7:0] shi, logic [7:0] slo, logic [11:0] periods,
                              logic [11:0] astart, logic [11:0] npix);
      write_reg(CSR_INTEGRATION_CYCLES, integ);
      write_reg(CSR_SAMPLE_PHASE, 16'(phase));
      write_reg(CSR_CLEAR_PULSES, clear);
      write_reg(CSR_SHIFT_HIGH_CYCLES, 16'(shi));
      write_reg(CSR_SHIFT_LOW_CYCLES, 16'(slo));
      write_reg(CSR_READOUT_PERIODS, 16'(periods));
      write_reg(CSR_ACTIVE_START, 16'(astart));
      write_reg(CSR_PIXEL_COUNT, 16'(npix));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Ticks that a full capture takes from start to idle under the shadow config
   function automatic int unsigned capture_ticks();
      int unsigned pulse_len;
      int unsigned n;
      pulse_len = int'(cfg_shi) + int'(cfg_slo);
      n = 0;
      if (pulse_len != 0) n = int'(cfg_clear) * pulse_len * 2;
      n += 2 * int'(cfg_integ) + 1 + 2 * int'(cfg_shi) + 2 * int'(XTAIL_CYCLES);
      n += 4 * int'(cfg_periods) + 1;
      return n;
   endfunction

   // Start request, then ticks with a sprinkle of stray starts
   task automatic queue_capture(int unsigned ticks);
      queue_item(1'b1, 12'($urandom_range(4095)));
      repeat (ticks) queue_item($urandom_range(99) < 3, 12'($urandom_range(4095)));
      captures_run++;
   endtask

   // Hold the sender until every result is back, then let the block settle
   task automatic wait_drained();
      while (outputs_checked != items_queued) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Short random configs, mostly full captures, some cut off mid-sequence
   task automatic run_setting(int unsigned send_pct, int unsigned recv_pct, bit with_hold);
      int unsigned first_item;
      int unsigned ticks;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      first_item = items_queued;
      while (items_queued - first_item < SETTING_ITEMS) begin
         load_config(16'($urandom_range(6)), 2'($urandom_range(3)), 16'($urandom_range(3)),
                     8'($urandom_range(3)), 8'($urandom_range(3)),
                     12'($urandom_range(12)), 12'($urandom_range(6)),
                     12'($urandom_range(8)));
         ticks = capture_ticks() + $urandom_range(1, 4);
         if ($urandom_range(99) < 20) ticks = $urandom_range(1, ticks);
         if (with_hold) begin
            hold_requests++;
            with_hold = 1'b0;
         end
         queue_capture(ticks);
         wait_drained();
      end
   endtask

   initial begin : stimulus
      int k;
      while (reset) @(posedge clock);

      // Directed: zero-length segments, ignored start, single last pixel, back to idle
      load_config(16'd0, 2'd3, 16'd0, 8'd0, 8'd0, 12'd2, 12'd1, 12'd1);
      queue_item(1'b0, 12'h000);
      queue_item(1'b1, 12'hFFF);
      queue_item(1'b1, 12'h000);
      for (k = 0; k < 19; k++) queue_item(1'b0, k[0] ? 12'h555 : 12'hFFF);
      captures_run++;
      wait_drained();

      // Register extremes, then shrink the limits mid-capture
      load_config(16'hFFFF, 2'd3, 16'hFFFF, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF, 12'hFFF);
      queue_capture(40);
      wait_drained();
      load_config(16'd0, 2'd1, 16'd0, 8'd0, 8'd0, 12'hFFF, 12'd0, 12'hFFF);
      queue_capture(64);
      wait_drained();

      run_setting(18, 78, 1'b0);
      run_setting(78, 18, 1'b0);
      run_setting(0, 0, 1'b1);

      wait_drained();
      repeat (4) @(posedge clock);
      $display("Ran %0d items over %0d capture sequences, %0d results checked,",
               items_taken, captures_run, outputs_checked);
      $display("including %0d active pixels and %0d line ends.", pixels_seen, line_ends_seen);
      if (n_fail == 0 && awaited_outputs.size() == 0) begin
         $display("linear_ccd_capture_sequencer_top_test: PASS");
      end else begin
         $display("linear_ccd_capture_sequencer_top_test: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
rtl/lccd_pkg.sv
rtl/linear_ccd_capture_sequencer_top.sv
sim/linear_ccd_capture_sequencer_top_test.sv
